>>> rtl/core/ddo_pkg.sv
package ddo_pkg;

   localparam int SPEED_W   = 16;
   localparam int HEADING_W = 15;
   localparam int ANGLE_W   = 28;
   localparam int TABLE_LEN = 24;
   localparam int CFG_AW    = 3;

   localparam logic signed [15:0] PI_Q12      = 16'sd12868;
   localparam logic signed [15:0] TWO_PI_Q12  = 16'sd25736;
   localparam logic signed [ANGLE_W-1:0] PI_Q24      = 28'sd52707179;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic signed [ANGLE_W-1:0] GAIN_Q24    = 28'sd10188014;

   localparam logic [CFG_AW-1:0] ADDR_RADIUS            = 3'd0;
   localparam logic [CFG_AW-1:0] ADDR_INVERSE_WHEELBASE = 3'd4;

   localparam logic [15:0] RADIUS_RESET    = 16'd3277;
   localparam logic [15:0] INV_BASE_RESET  = 16'd1347;

   function automatic logic signed [ANGLE_W-1:0] atan_q24(input logic [4:0] i);
      logic signed [ANGLE_W-1:0] r;
      r = '0;
      case (i)
         5'd0: r = 28'sd13176795;
         5'd1: r = 28'sd7778716;
         5'd2: r = 28'sd4110060;
         5'd3: r = 28'sd2086331;
         5'd4: r = 28'sd1047214;
         5'd5: r = 28'sd524117;
         5'd6: r = 28'sd262123;
         5'd7: r = 28'sd131069;
         default: begin
            if (i < 5'd24) begin
               r = 28'sd1 <<< (5'd24 - i);
            end else begin
               r = '0;
            end
         end
      endcase
      return r;
   endfunction

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_VEL   = 7'b0000010,
      ST_SAT   = 7'b0000100,
      ST_ROT   = 7'b0001000,
      ST_MUL1  = 7'b0010000,
      ST_MUL2  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic vel;
      logic sat;
      logic rot_start;
      logic rot_step;
      logic mul1;
      logic mul2;
   } cmd_type;

   typedef struct packed {
      logic rot_done;
   } status_type;

endpackage

>>> rtl/core/ddo_control.sv
module ddo_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ddo_pkg::status_type status,
   output ddo_pkg::cmd_type    cmd
);

   ddo_pkg::state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      out_valid_in = out_valid_ff & rsp_stall;
      case (state_ff)
         ddo_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ddo_pkg::ST_VEL;
            end
         end
         ddo_pkg::ST_VEL: begin
            cmd.vel = 1'b1;
            state_in = ddo_pkg::ST_SAT;
         end
         ddo_pkg::ST_SAT: begin
            cmd.sat = 1'b1;
            cmd.rot_start = 1'b1;
            state_in = ddo_pkg::ST_ROT;
         end
         ddo_pkg::ST_ROT: begin
            cmd.rot_step = 1'b1;
            if (status.rot_done) begin
               cmd.rot_step = 1'b0;
               state_in = ddo_pkg::ST_MUL1;
            end
         end
         ddo_pkg::ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ddo_pkg::ST_MUL2;
         end
         ddo_pkg::ST_MUL2: begin
            if (!out_valid_ff || !rsp_stall) begin
               cmd.mul2 = 1'b1;
               out_valid_in = 1'b1;
               state_in = ddo_pkg::ST_IDLE;
            end
         end
         default: state_in = ddo_pkg::ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ddo_pkg::ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddo_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> rtl/core/ddo_datapath.sv
module ddo_datapath #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int POSITION_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  ddo_pkg::cmd_type    cmd,
   output ddo_pkg::status_type status,
   input  logic [15:0]         radius,
   input  logic [15:0]         inverse_wheelbase,
   input  logic signed [15:0]  req_right_wheel_speed,
   input  logic signed [15:0]  req_left_wheel_speed,
   input  logic [15:0]         req_time_step,
   output logic signed [31:0]  rsp_position_x,
   output logic signed [31:0]  rsp_position_y,
   output logic signed [14:0]  rsp_heading,
   output logic signed [15:0]  rsp_linear_velocity,
   output logic signed [15:0]  rsp_angular_velocity
);

   localparam int N_IT = (CORDIC_ITERATIONS > ddo_pkg::TABLE_LEN) ?
                         ddo_pkg::TABLE_LEN : CORDIC_ITERATIONS;
   localparam int AW = ddo_pkg::ANGLE_W;
   localparam int PW = POSITION_WIDTH;

   logic signed [16:0] sum_ff, diff_ff;
   logic [15:0] dt_ff;
   logic signed [33:0] vprod_ff;
   logic signed [33:0] wprod_ff;
   logic signed [15:0] v_ff, w_ff;
   logic signed [AW-1:0] x_ff, y_ff, z_ff;
   logic flip_ff;
   logic [4:0] it_ff;
   logic signed [47:0] vcdt_x_ff, vcdt_y_ff;
   logic signed [PW-1:0] px_ff, py_ff;
   logic signed [15:0] h_ff;
   logic signed [31:0] ox_ff, oy_ff;
   logic signed [14:0] oh_ff;
   logic signed [15:0] ov_ff, ow_ff;

   logic signed [50:0] wfull;
   logic signed [34:0] vr;
   logic signed [50:0] wr_;
   logic signed [AW-1:0] z0, xs, ys;
   logic signed [AW-1:0] vx, vy;
   logic signed [47:0] mx, my;
   logic signed [64:0] dx_full, dy_full;
   logic signed [32:0] dx, dy;
   logic signed [32:0] hw;
   logic signed [20:0] dh;
   logic signed [21:0] hsum;

   function automatic logic signed [15:0] sat16(input logic signed [50:0] a);
      if (a > 51'sd32767) begin
         return 16'sh7fff;
      end else if (a < -51'sd32768) begin
         return -16'sh8000;
      end
      return a[15:0];
   endfunction

   assign status.rot_done = (it_ff == 5'(N_IT));

   always_comb begin
      vr = 35'(vprod_ff) + 35'sd65536;
      wfull = 51'(wprod_ff) * $signed({1'b0, inverse_wheelbase});
      wr_ = (wfull + 51'sd8388608) >>> 24;
      z0 = AW'(h_ff) <<< 12;
      xs = x_ff >>> it_ff;
      ys = y_ff >>> it_ff;
      vx = flip_ff ? -x_ff : x_ff;
      vy = flip_ff ? -y_ff : y_ff;
      mx = 48'(v_ff) * 48'(vx);
      my = 48'(v_ff) * 48'(vy);
      dx_full = 65'(vcdt_x_ff) * $signed({1'b0, dt_ff}) + (65'sd1 <<< 31);
      dy_full = 65'(vcdt_y_ff) * $signed({1'b0, dt_ff}) + (65'sd1 <<< 31);
      dx = 33'(dx_full >>> 32);
      dy = 33'(dy_full >>> 32);
      hw = 33'(w_ff) * $signed({1'b0, dt_ff});
      dh = 21'((hw + 33'sd2048) >>> 12);
      hsum = 22'(h_ff) + 22'(dh);
      if (hsum > 22'(ddo_pkg::PI_Q12)) begin
         hsum = hsum - 22'(ddo_pkg::TWO_PI_Q12);
      end else if (hsum < -22'(ddo_pkg::PI_Q12)) begin
         hsum = hsum + 22'(ddo_pkg::TWO_PI_Q12);
      end
      if (hsum > 22'(ddo_pkg::PI_Q12)) begin
         hsum = 22'(ddo_pkg::PI_Q12);
      end else if (hsum < -22'(ddo_pkg::PI_Q12)) begin
         hsum = -22'(ddo_pkg::PI_Q12);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sum_ff <= 17'(req_right_wheel_speed) + 17'(req_left_wheel_speed);
         diff_ff <= 17'(req_right_wheel_speed) - 17'(req_left_wheel_speed);
         dt_ff <= req_time_step;
      end
      if (cmd.vel) begin
         vprod_ff <= 34'(sum_ff) * $signed({1'b0, radius});
         wprod_ff <= 34'(diff_ff) * $signed({1'b0, radius});
      end
      if (cmd.sat) begin
         v_ff <= sat16(51'(vr >>> 17));
         w_ff <= sat16(wr_);
      end
      if (cmd.rot_start) begin
         x_ff <= ddo_pkg::GAIN_Q24;
         y_ff <= '0;
         it_ff <= '0;
         if (z0 > ddo_pkg::HALF_PI_Q24) begin
            z_ff <= z0 - ddo_pkg::PI_Q24;
            flip_ff <= 1'b1;
         end else if (z0 < -ddo_pkg::HALF_PI_Q24) begin
            z_ff <= z0 + ddo_pkg::PI_Q24;
            flip_ff <= 1'b1;
         end else begin
            z_ff <= z0;
            flip_ff <= 1'b0;
         end
      end else if (cmd.rot_step) begin
         it_ff <= it_ff + 5'd1;
         if (!z_ff[AW-1]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - ddo_pkg::atan_q24(it_ff);
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + ddo_pkg::atan_q24(it_ff);
         end
      end
      if (cmd.mul1) begin
         vcdt_x_ff <= mx;
         vcdt_y_ff <= my;
      end
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
         h_ff <= '0;
      end else if (cmd.mul2) begin
         px_ff <= px_ff + PW'(dx);
         py_ff <= py_ff + PW'(dy);
         h_ff <= 16'(hsum);
         ox_ff <= 32'(px_ff + PW'(dx));
         oy_ff <= 32'(py_ff + PW'(dy));
         oh_ff <= 15'(hsum);
         ov_ff <= v_ff;
         ow_ff <= w_ff;
      end
   end

   assign rsp_position_x = ox_ff;
   assign rsp_position_y = oy_ff;
   assign rsp_heading = oh_ff;
   assign rsp_linear_velocity = ov_ff;
   assign rsp_angular_velocity = ow_ff;

endmodule

>>> rtl/core/differential_drive_odometry_unit.sv
// an accepted item is loaded in idle, then passes the velocity, saturation, cordic rotation and mul1/mul2 states
// no new item is accepted until the state machine is back in idle (req_stall), and the cordic rotation is serial
// the next item is taken while a finished result waits in the output register
// reset: synchronous, clears position and heading, loads default radius and wheelbase
module differential_drive_odometry_unit #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int POSITION_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_right_wheel_speed,
   input  logic signed [15:0] req_left_wheel_speed,
   input  logic [15:0]        req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_position_x,
   output logic signed [31:0] rsp_position_y,
   output logic signed [14:0] rsp_heading,
   output logic signed [15:0] rsp_linear_velocity,
   output logic signed [15:0] rsp_angular_velocity,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ddo_pkg::CFG_AW-1:0] csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   ddo_pkg::cmd_type cmd;
   ddo_pkg::status_type status;
   logic [15:0] radius_ff, inv_base_ff;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= ddo_pkg::RADIUS_RESET;
         inv_base_ff <= ddo_pkg::INV_BASE_RESET;
      end else if (wr_en) begin
         if (csr_paddr == ddo_pkg::ADDR_RADIUS) begin
            radius_ff <= csr_pwdata[15:0];
         end else if (csr_paddr == ddo_pkg::ADDR_INVERSE_WHEELBASE) begin
            inv_base_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ddo_pkg::ADDR_RADIUS) begin
         csr_prdata = {16'd0, radius_ff};
      end else if (csr_paddr == ddo_pkg::ADDR_INVERSE_WHEELBASE) begin
         csr_prdata = {16'd0, inv_base_ff};
      end
   end

   ddo_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .status(status), .cmd(cmd)
   );

   ddo_datapath #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .radius(radius_ff), .inverse_wheelbase(inv_base_ff),
      .req_right_wheel_speed(req_right_wheel_speed),
      .req_left_wheel_speed(req_left_wheel_speed),
      .req_time_step(req_time_step),
      .rsp_position_x(rsp_position_x), .rsp_position_y(rsp_position_y),
      .rsp_heading(rsp_heading),
      .rsp_linear_velocity(rsp_linear_velocity),
      .rsp_angular_velocity(rsp_angular_velocity)
   );

endmodule
